[rtl/core/am2d_pkg.sv]
`default_nettype none
package am2d_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_STEPS_MAX = 30;

  localparam logic signed [33:0] DEG360 = 34'sd23592960;
  localparam logic signed [33:0] DEG180 = 34'sd11796480;
  localparam logic signed [33:0] DEG90  = 34'sd5898240;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] angle_deg;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic               aim;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] m_cos_sx;
    logic signed [31:0] m_sin_sx;
    logic signed [31:0] m_negsin_sy;
    logic signed [31:0] m_cos_sy;
    logic signed [31:0] m_tx;
    logic signed [31:0] m_ty;
    logic signed [31:0] angle_used;
  } out_beat_t;

  // atan(2^-i) in degrees, Q16.16
  function automatic logic signed [33:0] atan_deg(input int i);
    case (i)
      0: return 34'sd2949120;  1: return 34'sd1740967;  2: return 34'sd919879;
      3: return 34'sd466945;   4: return 34'sd234379;   5: return 34'sd117304;
      6: return 34'sd58666;    7: return 34'sd29335;    8: return 34'sd14668;
      9: return 34'sd7334;     10: return 34'sd3667;    11: return 34'sd1833;
      12: return 34'sd917;     13: return 34'sd458;     14: return 34'sd229;
      15: return 34'sd115;     16: return 34'sd57;      17: return 34'sd29;
      18: return 34'sd14;      19: return 34'sd7;       20: return 34'sd4;
      21: return 34'sd2;       22: return 34'sd1;
      default: return 34'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

[rtl/core/am2d_mul_sat.sv]
`default_nettype none
// Registered Q2.30 x Q16.16 product, rounded half up, saturated to 32 bits.
module am2d_mul_sat import am2d_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [32:0] a,
  input  wire logic signed [31:0] b,
  output logic signed [31:0]      p
);
  logic signed [64:0] prod_r;
  logic signed [34:0] sh;

  always_ff @(posedge clk) begin
    if (en) prod_r <= a * b;
  end

  assign sh = 35'((prod_r + 65'sd536870912) >>> 30);

  always_comb begin
    if (sh > 35'sd2147483647) p = 32'sh7fffffff;
    else if (sh < -35'sd2147483648) p = 32'sh80000000;
    else p = sh[31:0];
  end
endmodule
`default_nettype wire

[rtl/core/affine_2d_matrix_from_pose.sv]
`default_nettype none
// Channel | Ports                          | Payload
// in      | in_valid  in_ready  in_data    | in_beat_t  (pose, aim, target)
// out     | out_valid out_ready out_data   | out_beat_t (matrix, angle_used)
//
// One beat per cycle sustained while out_ready stays high.
// Stages: difference, vectoring steps, angle split and divide, remainder,
// fold, rotation steps, product register, output register. Each CORDIC
// iteration owns one stage.
// The whole pipe advances when the output register is empty or being taken,
// so a stall holds every stage and nothing is lost or repeated.
// Reset (synchronous, rst_n low) clears the valid bits only.
module affine_2d_matrix_from_pose import am2d_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);
  localparam int N = CORDIC_STEPS;
  // ceil(2^24 / 360): exact quotient for every 16-bit dividend
  localparam logic [31:0] RECIP_360 = 32'd46604;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 0: differences
  logic        v0_r;
  in_beat_t    d0_r;
  logic signed [32:0] dx0_r, dy0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_valid;
    if (adv) begin
      d0_r  <= in_data;
      dx0_r <= 33'(in_data.target_x) - 33'(in_data.pos_x);
      dy0_r <= 33'(in_data.target_y) - 33'(in_data.pos_y);
    end
  end

  // vectoring chain: element 0 is prepared from stage 0, then N steps
  logic               vv_r [N+1];
  in_beat_t           vd_r [N+1];
  logic signed [58:0] vx_r [N+1];
  logic signed [58:0] vy_r [N+1];
  logic signed [33:0] vz_r [N+1];
  logic               vzero_r [N+1];

  logic signed [58:0] sx0, sy0;
  assign sx0 = 59'(dx0_r) <<< 24;
  assign sy0 = 59'(dy0_r) <<< 24;

  always_ff @(posedge clk) begin
    if (!rst_n) vv_r[0] <= 1'b0;
    else if (adv) vv_r[0] <= v0_r;
    if (adv) begin
      vd_r[0]    <= d0_r;
      vzero_r[0] <= (dx0_r == 33'sd0) && (dy0_r == 33'sd0);
      if (sx0 < 0) begin
        vx_r[0] <= -sx0;
        vy_r[0] <= -sy0;
        vz_r[0] <= (sy0 >= 0) ? DEG180 : -DEG180;
      end else begin
        vx_r[0] <= sx0;
        vy_r[0] <= sy0;
        vz_r[0] <= 34'sd0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (!rst_n) vv_r[i+1] <= 1'b0;
      else if (adv) vv_r[i+1] <= vv_r[i];
      if (adv) begin
        vd_r[i+1]    <= vd_r[i];
        vzero_r[i+1] <= vzero_r[i];
        if (vy_r[i] > 0) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + atan_deg(i);
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - atan_deg(i);
        end
      end
    end
  end

  // reduction, first half: split the angle into whole degrees and fraction.
  // Offset the whole degrees by 32768 (flip the sign bit) so they are
  // unsigned, then divide by 360 with a reciprocal multiply.
  logic signed [31:0] raw;
  logic        [15:0] raw_u;
  logic        [31:0] raw_q;
  always_comb begin
    if (vd_r[N].aim) raw = vzero_r[N] ? 32'sd0 : vz_r[N][31:0];
    else raw = vd_r[N].angle_deg;
    raw_u = {~raw[31], raw[30:16]};
    raw_q = 32'(raw_u) * RECIP_360;
  end

  logic        rq_v_r;
  in_beat_t    rq_d_r;
  logic [15:0] rq_u_r;
  logic [15:0] rq_f_r;
  logic [7:0]  rq_q_r;
  always_ff @(posedge clk) begin
    if (!rst_n) rq_v_r <= 1'b0;
    else if (adv) rq_v_r <= vv_r[N];
    if (adv) begin
      rq_d_r <= vd_r[N];
      rq_u_r <= raw_u;
      rq_f_r <= raw[15:0];
      rq_q_r <= raw_q[31:24];
    end
  end

  // reduction, second half: remainder, undo the offset (32768 mod 360 = 8),
  // rebuild the angle in [0, 360) and move it into (-180, 180]
  logic        [15:0] rem_w;
  logic signed [9:0]  deg_w;
  logic signed [33:0] red;
  always_comb begin
    rem_w = rq_u_r - 16'(rq_q_r) * 16'd360;
    deg_w = $signed({1'b0, rem_w[8:0]}) - 10'sd8;
    if (deg_w < 0) deg_w = deg_w + 10'sd360;
    red = $signed({9'd0, deg_w[8:0], rq_f_r});
    if (red > DEG180) red = red - DEG360;
  end

  logic               ru_v_r;
  in_beat_t           ru_d_r;
  logic signed [33:0] ru_a_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ru_v_r <= 1'b0;
    else if (adv) ru_v_r <= rq_v_r;
    if (adv) begin
      ru_d_r <= rq_d_r;
      ru_a_r <= red;
    end
  end

  // rotation chain: element 0 holds the folded angle
  logic               rv_r [N+1];
  in_beat_t           rd_r [N+1];
  logic signed [33:0] ru_r [N+1];
  logic               rneg_r [N+1];
  logic signed [33:0] rx_r [N+1];
  logic signed [33:0] ry_r [N+1];
  logic signed [33:0] rz_r [N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) rv_r[0] <= 1'b0;
    else if (adv) rv_r[0] <= ru_v_r;
    if (adv) begin
      rd_r[0] <= ru_d_r;
      ru_r[0] <= ru_a_r;
      rx_r[0] <= GAIN_Q30;
      ry_r[0] <= 34'sd0;
      if (ru_a_r > DEG90) begin
        rz_r[0] <= ru_a_r - DEG180; rneg_r[0] <= 1'b1;
      end else if (ru_a_r < -DEG90) begin
        rz_r[0] <= ru_a_r + DEG180; rneg_r[0] <= 1'b1;
      end else begin
        rz_r[0] <= ru_a_r; rneg_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (!rst_n) rv_r[i+1] <= 1'b0;
      else if (adv) rv_r[i+1] <= rv_r[i];
      if (adv) begin
        rd_r[i+1]   <= rd_r[i];
        ru_r[i+1]   <= ru_r[i];
        rneg_r[i+1] <= rneg_r[i];
        if (rz_r[i] >= 0) begin
          rx_r[i+1] <= rx_r[i] - (ry_r[i] >>> i);
          ry_r[i+1] <= ry_r[i] + (rx_r[i] >>> i);
          rz_r[i+1] <= rz_r[i] - atan_deg(i);
        end else begin
          rx_r[i+1] <= rx_r[i] + (ry_r[i] >>> i);
          ry_r[i+1] <= ry_r[i] - (rx_r[i] >>> i);
          rz_r[i+1] <= rz_r[i] + atan_deg(i);
        end
      end
    end
  end

  // apply the fold sign; sin/cos fit in 33 bits
  logic signed [32:0] c_fin, s_fin, ns_fin;
  assign c_fin  = rneg_r[N] ? 33'(-rx_r[N]) : 33'(rx_r[N]);
  assign s_fin  = rneg_r[N] ? 33'(-ry_r[N]) : 33'(ry_r[N]);
  assign ns_fin = 33'(-34'(s_fin));

  // product stage: multipliers register internally
  logic        pv_r;
  in_beat_t    pd_r;
  logic signed [31:0] pa_r;
  logic signed [31:0] p_cx, p_sx, p_nsy, p_cy;
  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else if (adv) pv_r <= rv_r[N];
    if (adv) begin
      pd_r <= rd_r[N];
      pa_r <= ru_r[N][31:0];
    end
  end

  am2d_mul_sat u_cx  (.clk(clk), .en(adv), .a(c_fin),  .b(rd_r[N].scale_x), .p(p_cx));
  am2d_mul_sat u_sx  (.clk(clk), .en(adv), .a(s_fin),  .b(rd_r[N].scale_x), .p(p_sx));
  am2d_mul_sat u_nsy (.clk(clk), .en(adv), .a(ns_fin), .b(rd_r[N].scale_y), .p(p_nsy));
  am2d_mul_sat u_cy  (.clk(clk), .en(adv), .a(c_fin),  .b(rd_r[N].scale_y), .p(p_cy));

  // output register
  logic      ov_r;
  out_beat_t od_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= pv_r;
    if (adv) begin
      od_r.m_cos_sx    <= p_cx;
      od_r.m_sin_sx    <= p_sx;
      od_r.m_negsin_sy <= p_nsy;
      od_r.m_cos_sy    <= p_cy;
      od_r.m_tx        <= pd_r.pos_x;
      od_r.m_ty        <= pd_r.pos_y;
      od_r.angle_used  <= pa_r;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  // a stalled result must hold
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // ready follows the output register
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("ready mismatch");
  // angle applied lies in (-180, 180]
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.angle_used <= 32'sd11796480) &&
                  (out_data.angle_used > -32'sd11796480))
    else $error("angle out of range");
endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import am2d_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int PIPE_LAT = 2 * STEPS + 7;

  // Q16.16 degree constants and the CORDIC start gain, held wide for the predictor
  localparam longint FULL_TURN = 64'sd23592960;
  localparam longint HALF_TURN = 64'sd11796480;
  localparam longint QTR_TURN  = 64'sd5898240;
  localparam longint START_K   = 64'sd652032874;
  localparam longint VEC_GAIN  = 64'sd16777216;
  localparam int     MAX_SHOWN = 10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  out_beat_t matrix_q[$];
  int        n_sent;
  int        n_got;
  int        n_bad;
  int        n_aim;
  bit        stall_rx;      // random receiver hold-offs enabled
  bit        long_hold;     // long receiver hold-off in progress
  bit        gap_tx;        // random sender gaps enabled

  affine_2d_matrix_from_pose #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  // arctangent of 2^-i in Q16.16 degrees
  function automatic longint atan_step(int i);
    longint tab[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                        57, 29, 14, 7, 4, 2, 1};
    return (i < 23) ? tab[i] : 64'sd0;
  endfunction

  // wrap an angle into (-180, 180]
  function automatic longint wrap_deg(longint a);
    longint r;
    r = a % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    if (r > HALF_TURN) r -= FULL_TURN;
    return r;
  endfunction

  // Q2.30 by Q16.16, round half up, clamp to 32 bits
  function automatic logic signed [31:0] scale_sat(longint q30, longint q16);
    longint p;
    p = (q30 * q16 + (64'sd1 <<< 29)) >>> 30;
    if (p > 64'sd2147483647) return 32'sh7fffffff;
    if (p < -64'sd2147483648) return 32'sh80000000;
    return p[31:0];
  endfunction

  // vectoring CORDIC: direction of (dx, dy) in degrees, zero vector gives 0
  function automatic longint heading_deg(longint dy, longint dx);
    longint x, y, z, sx, sy;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    x = dx * VEC_GAIN;
    y = dy * VEC_GAIN;
    if (x < 0) begin
      // pointing backwards: turn half a circle first
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (y > 0) begin
        x += sx; y -= sy; z += atan_step(i);
      end else begin
        x -= sx; y += sy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic out_beat_t pose_matrix(in_beat_t p);
    out_beat_t m;
    longint used, x, y, z, sx, sy, s, c;
    bit flip;
    if (p.aim)
      used = wrap_deg(heading_deg(longint'(p.target_y) - longint'(p.pos_y),
                                  longint'(p.target_x) - longint'(p.pos_x)));
    else
      used = wrap_deg(longint'(p.angle_deg));
    // fold into [-90, 90], negating sine and cosine afterwards
    z = used;
    flip = 1'b0;
    if (z > QTR_TURN) begin
      z -= HALF_TURN; flip = 1'b1;
    end else if (z < -QTR_TURN) begin
      z += HALF_TURN; flip = 1'b1;
    end
    x = START_K;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (z >= 0) begin
        x -= sx; y += sy; z -= atan_step(i);
      end else begin
        x += sx; y -= sy; z += atan_step(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    m.m_cos_sx    = scale_sat(c, p.scale_x);
    m.m_sin_sx    = scale_sat(s, p.scale_x);
    m.m_negsin_sy = scale_sat(-s, p.scale_y);
    m.m_cos_sy    = scale_sat(c, p.scale_y);
    m.m_tx        = p.pos_x;
    m.m_ty        = p.pos_y;
    m.angle_used  = used[31:0];
    return m;
  endfunction

  // ---------------------------------------------------------------- sender
  // Offer one pose and hold it until accepted; valid is left high, so the next
  // call keeps it high across beats, and release_input drops it.
  task automatic send_pose(in_beat_t p);
    int gap;
    if (gap_tx && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    matrix_q.push_back(pose_matrix(p));
    n_sent++;
    if (p.aim) n_aim++;
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rnd32();
    return $urandom();
  endfunction

  // values biased towards edges and moderate magnitudes
  function automatic logic signed [31:0] pick_q16();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      4: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      default: return rnd32();
    endcase
  endfunction

  function automatic in_beat_t rand_pose();
    in_beat_t p;
    p.pos_x     = pick_q16();
    p.pos_y     = pick_q16();
    p.angle_deg = ($urandom_range(0, 1)) ? rnd32()
                  : $signed($urandom_range(0, 48_000_000)) - 32'sd24_000_000;
    p.scale_x   = pick_q16();
    p.scale_y   = pick_q16();
    p.aim       = $urandom_range(0, 1);
    p.target_x  = ($urandom_range(0, 9) == 0) ? p.pos_x : pick_q16();
    p.target_y  = ($urandom_range(0, 9) == 0) ? p.pos_y : pick_q16();
    return p;
  endfunction

  function automatic in_beat_t plain_pose(logic signed [31:0] ang);
    in_beat_t p;
    p = '0;
    p.pos_x = 32'sh0001_0000;
    p.pos_y = -32'sh0002_8000;
    p.angle_deg = ang;
    p.scale_x = 32'sh0001_0000;
    p.scale_y = 32'sh0002_0000;
    return p;
  endfunction

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    int hold;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold) begin
      out_ready <= 1'b0;
    end else if (stall_rx && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      hold = $urandom_range(1, 15);
      repeat (hold) @(posedge clk);
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // check each beat taken at the edge against the oldest prediction
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      n_got++;
      if (matrix_q.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_SHOWN) $display("unexpected result beat %p", out_data);
      end else begin
        want = matrix_q.pop_front();
        if (want !== out_data) begin
          n_bad++;
          if (n_bad <= MAX_SHOWN)
            $display("mismatch at result %0d:\n  exp %p\n  got %p", n_got, want, out_data);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_angles();
    logic signed [31:0] angs[14] = '{32'sd0, 32'sd5898240, -32'sd5898240, 32'sd11796480,
      -32'sd11796480, 32'sd23592960, -32'sd23592960, 32'sd5898241, -32'sd5898241,
      32'sd2949120, 32'sh7fffffff, 32'sh80000000, 32'sd17694720, 32'sd1};
    foreach (angs[i]) send_pose(plain_pose(angs[i]));
  endtask

  task automatic test_saturation();
    in_beat_t p;
    p = plain_pose(32'sd0);
    p.scale_x = 32'sh7fffffff; p.scale_y = 32'sh80000000;
    send_pose(p);
    p.angle_deg = 32'sd11796480;
    send_pose(p);
    p.pos_x = 32'sh80000000; p.pos_y = 32'sh7fffffff; p.angle_deg = -32'sd2949120;
    send_pose(p);
  endtask

  task automatic test_aim();
    in_beat_t p;
    p = plain_pose(32'sd1234567);
    p.aim = 1'b1;
    p.target_x = p.pos_x; p.target_y = p.pos_y;        // target on the pose
    send_pose(p);
    p.target_x = p.pos_x - 32'sh0001_0000;             // straight behind, dy zero
    send_pose(p);
    p.target_y = p.pos_y - 32'sh0000_0001;             // behind and just below
    send_pose(p);
    p.target_x = p.pos_x; p.target_y = p.pos_y + 32'sh0003_0000;
    send_pose(p);
    p.pos_x = 32'sh80000000; p.pos_y = 32'sh80000000;  // largest differences
    p.target_x = 32'sh7fffffff; p.target_y = 32'sh7fffffff;
    send_pose(p);
    p.pos_x = 32'sh7fffffff; p.target_x = 32'sh80000000; p.target_y = 32'sh80000000;
    send_pose(p);
  endtask

  task automatic test_backpressure();
    int hold;
    long_hold = 1'b1;
    fork
      begin
        hold = 4 * PIPE_LAT;
        repeat (hold) @(posedge clk);
        long_hold = 1'b0;
      end
      repeat (3 * PIPE_LAT) send_pose(rand_pose());
    join
  endtask

  task automatic test_random(int count);
    repeat (count) send_pose(rand_pose());
  endtask

  task automatic drain();
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    n_sent = 0; n_got = 0; n_bad = 0; n_aim = 0;
    stall_rx = 1'b0; long_hold = 1'b0; gap_tx = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_angles();
    test_saturation();
    test_aim();
    release_input();
    stall_rx = 1'b1; gap_tx = 1'b1;
    test_backpressure();
    test_random(1000);
    // final stretch at full rate on both sides
    stall_rx = 1'b0; gap_tx = 1'b0;
    test_random(280);
    release_input();
    drain();

    $display("Sent %0d poses (%0d aimed), checked %0d matrix beats, %0d mismatches.",
             n_sent, n_aim, n_got, n_bad);
    if (n_bad == 0 && matrix_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
